// ===== hw/rtl/kfdt_pkg.sv =====
// Shared types, constants and face helpers for the keyed face-direction table.
package kfdt_pkg;

  localparam int unsigned FACE_COUNT = 6;
  localparam int unsigned VAL_W      = 5;
  localparam int unsigned FACES_W    = FACE_COUNT * VAL_W;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned FACE_W     = 3;

  localparam logic [VAL_W-1:0]   NO_ARROW     = '1;
  localparam logic [FACES_W-1:0] ALL_NO_ARROW = '1;

  typedef enum logic [1:0] {
    OP_WRITE_ALL = 2'd0,
    OP_WRITE_ONE = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_CLEAR     = 2'd3
  } kfdt_op_e;

  // One operation as it travels down the chain of entry cells.
  typedef struct packed {
    kfdt_op_e           op;
    logic [KEY_W-1:0]   key;
    logic [FACE_W-1:0]  face;
    logic [VAL_W-1:0]   face_value;
    logic [FACES_W-1:0] arrows;
    logic               found;
    logic               appended;
    logic [VAL_W-1:0]   read;
  } kfdt_tok_t;

  // Per-cell view of the fill level: the entry is valid, or it is the append slot.
  typedef struct packed {
    logic live;
    logic tail;
  } kfdt_cell_ctl_t;

  function automatic logic [VAL_W-1:0] get_face(logic [FACES_W-1:0] word,
                                                logic [FACE_W-1:0] face);
    logic [VAL_W-1:0] val;
    unique case (face)
      3'd0:    val = word[0*VAL_W +: VAL_W];
      3'd1:    val = word[1*VAL_W +: VAL_W];
      3'd2:    val = word[2*VAL_W +: VAL_W];
      3'd3:    val = word[3*VAL_W +: VAL_W];
      3'd4:    val = word[4*VAL_W +: VAL_W];
      3'd5:    val = word[5*VAL_W +: VAL_W];
      default: val = NO_ARROW;
    endcase
    return val;
  endfunction

  function automatic logic [FACES_W-1:0] set_face(logic [FACES_W-1:0] word,
                                                 logic [FACE_W-1:0] face,
                                                 logic [VAL_W-1:0] val);
    logic [FACES_W-1:0] res;
    res = word;
    unique case (face)
      3'd0:    res[0*VAL_W +: VAL_W] = val;
      3'd1:    res[1*VAL_W +: VAL_W] = val;
      3'd2:    res[2*VAL_W +: VAL_W] = val;
      3'd3:    res[3*VAL_W +: VAL_W] = val;
      3'd4:    res[4*VAL_W +: VAL_W] = val;
      3'd5:    res[5*VAL_W +: VAL_W] = val;
      default: res = word;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/kfdt_cell.sv =====
// One table entry cell: holds a key and six faces and passes the operation on.
module kfdt_cell import kfdt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  kfdt_cell_ctl_t ctl_i,
  input  logic           valid_i,
  input  kfdt_tok_t      tok_i,
  output logic           valid_o,
  output kfdt_tok_t      tok_o
);

  logic [KEY_W-1:0]   key_q;
  logic [FACES_W-1:0] faces_q, faces_d;
  logic               valid_q;
  kfdt_tok_t          tok_q, tok_d;
  logic               is_write, hit, append, store;
  logic [FACES_W-1:0] base;

  always_comb begin
    is_write = (tok_i.op == OP_WRITE_ALL) || (tok_i.op == OP_WRITE_ONE);
    hit      = valid_i && ctl_i.live && !tok_i.found && (tok_i.op != OP_CLEAR) &&
               (key_q == tok_i.key);
    append   = valid_i && ctl_i.tail && !tok_i.found && is_write;
    store    = (hit && is_write) || append;

    base = append ? ALL_NO_ARROW : faces_q;
    if (tok_i.op == OP_WRITE_ALL) begin
      faces_d = tok_i.arrows;
    end else begin
      faces_d = set_face(base, tok_i.face, tok_i.face_value);
    end

    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      if (tok_i.op == OP_LOOKUP) begin
        tok_d.read = get_face(faces_q, tok_i.face);
      end
    end
    if (append) begin
      tok_d.appended = 1'b1;
    end
  end

  // Entry storage is undefined until an append writes it.
  always_ff @(posedge clk_i) begin
    if (en_i && store) begin
      faces_q <= faces_d;
    end
    if (en_i && append) begin
      key_q <= tok_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

// ===== hw/rtl/keyed_face_direction_table_core.sv =====
// Top level of the keyed face-direction table: a chain of entry cells and a result register.
//
//   Channel | Handshake              | Word contents
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid_i / in_ready_o | opcode, key, face, face_value, arrow_face0..5
//   out     | out_valid_o/out_ready_i | read_value, key_found, table_full_drop
//
// An accepted word walks down the chain of TABLE_DEPTH entry cells, one cell per cycle while
// the chain is not stalled, and its result is then loaded into the output register.
// The block works on one word at a time; in_ready_o drops from acceptance until the
// result is loaded into the output register, so a new word is only taken once the last
// one has left the chain. A waiting result does not block input.
// If a result reaches the end of the chain while the previous one is still unclaimed,
// the whole chain freezes until out_ready_i takes the older word.
// Reset clears the fill count and all handshake state; entry contents need no reset.
module keyed_face_direction_table_core import kfdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               opcode_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [FACE_W-1:0]        face_i,
  input  logic signed [VAL_W-1:0]  face_value_i,
  input  logic signed [VAL_W-1:0]  arrow_face0_i,
  input  logic signed [VAL_W-1:0]  arrow_face1_i,
  input  logic signed [VAL_W-1:0]  arrow_face2_i,
  input  logic signed [VAL_W-1:0]  arrow_face3_i,
  input  logic signed [VAL_W-1:0]  arrow_face4_i,
  input  logic signed [VAL_W-1:0]  arrow_face5_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic                     key_found_o,
  output logic                     table_full_drop_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Fill count: entries below it are valid and the cell at it is the append slot.
  logic [CntW-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic            out_valid_q, out_valid_d;
  logic [VAL_W-1:0] read_q;
  logic            found_q, drop_q;

  logic      chain_valid [TABLE_DEPTH+1];
  kfdt_tok_t chain_tok   [TABLE_DEPTH+1];
  kfdt_tok_t in_tok;
  logic      accept, chain_en, finish, last_is_write;
  kfdt_tok_t last_tok;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // The chain stalls only when a finished word would overwrite an unclaimed result.
  assign chain_en = !(chain_valid[TABLE_DEPTH] && out_valid_q && !out_ready_i);
  assign finish   = chain_valid[TABLE_DEPTH] && chain_en;
  assign last_tok = chain_tok[TABLE_DEPTH];

  always_comb begin
    in_tok.op         = kfdt_op_e'(opcode_i);
    in_tok.key        = key_i;
    in_tok.face       = face_i;
    in_tok.face_value = face_value_i;
    in_tok.arrows     = {arrow_face5_i, arrow_face4_i, arrow_face3_i,
                         arrow_face2_i, arrow_face1_i, arrow_face0_i};
    in_tok.found      = 1'b0;
    in_tok.appended   = 1'b0;
    in_tok.read       = NO_ARROW;
  end

  assign chain_valid[0] = accept;
  assign chain_tok[0]   = in_tok;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    kfdt_cell_ctl_t ctl;
    assign ctl.live = (CntW'(gi) < count_q);
    assign ctl.tail = (CntW'(gi) == count_q);

    kfdt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (chain_en),
      .ctl_i   (ctl),
      .valid_i (chain_valid[gi]),
      .tok_i   (chain_tok[gi]),
      .valid_o (chain_valid[gi+1]),
      .tok_o   (chain_tok[gi+1])
    );
  end

  assign last_is_write = (last_tok.op == OP_WRITE_ALL) || (last_tok.op == OP_WRITE_ONE);

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (last_tok.op == OP_CLEAR) begin
        count_d = '0;
      end else if (last_tok.appended) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A write that neither matched nor found a free slot was dropped for lack of room.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      read_q  <= last_tok.read;
      found_q <= last_tok.found;
      drop_q  <= last_is_write && !last_tok.found && !last_tok.appended;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_value_o      = $signed(read_q);
  assign key_found_o       = found_q;
  assign table_full_drop_o = drop_q;

endmodule

// ===== hw/rtl/kfdt_checker.sv =====
// Port-level assertions for the keyed face-direction table, bound to its top level.
module kfdt_checker import kfdt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [VAL_W-1:0] read_value_o,
  input logic                    key_found_o,
  input logic                    table_full_drop_o
);

  // A held result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  // A held result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(read_value_o) && $stable(key_found_o) && $stable(table_full_drop_o))
    else $error("result word changed while stalled");

  // Only one operation is in flight, so acceptance closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  // A dropped append never comes with a key match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_drop_o |-> !key_found_o)
    else $error("drop reported together with a key match");

  // A face value other than no-arrow is only returned on a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_value_o != -5'sd1) |-> key_found_o && !table_full_drop_o)
    else $error("face value returned without a key match");

endmodule

bind keyed_face_direction_table_core kfdt_checker u_kfdt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .read_value_o      (read_value_o),
  .key_found_o       (key_found_o),
  .table_full_drop_o (table_full_drop_o)
);
